>>> rtl/sfpf_pkg.sv
// Shared types and constants for the sync frame parser with Fletcher-8 check.
// Used by sfpf_core, sfpf_out_reg and sync_frame_parser_fletcher_top.
`default_nettype none

package sfpf_pkg;

  // Sync pair that opens every frame
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Header byte positions
  localparam logic [1:0] HDR_POS_CLASS  = 2'd0;
  localparam logic [1:0] HDR_POS_ID     = 2'd1;
  localparam logic [1:0] HDR_POS_LEN_LO = 2'd2;
  localparam logic [1:0] HDR_POS_LEN_HI = 2'd3;

  // Parser phases
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } phase_t;

  // One result item
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_offset;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] msg_length;
    logic        frame_done;
    logic        checksum_ok;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/sfpf_core.sv
// Parser state machine, header capture and Fletcher-8 sums.
// Depends on sfpf_pkg; computes one result per accepted byte.
`default_nettype none

module sfpf_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_en,
  input  wire logic [7:0]      rx_byte,
  output sfpf_pkg::result_t    res_nxt
);
  import sfpf_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        sync_matched_r, sync_matched_nxt;
  logic [1:0]  header_count_r, header_count_nxt;
  logic [7:0]  hdr_class_r, hdr_class_nxt;
  logic [7:0]  hdr_id_r, hdr_id_nxt;
  logic [15:0] hdr_length_r, hdr_length_nxt;
  logic [15:0] payload_count_r, payload_count_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  first_check_r, first_check_nxt;
  logic        check_count_r, check_count_nxt;

  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [15:0] payload_count_inc;
  logic        length_zero;
  logic        payload_last;

  // Running Fletcher-8 sums with the current byte folded in
  assign sum_a_add = sum_a_r + rx_byte;
  assign sum_b_add = sum_b_r + sum_a_add;

  assign payload_count_inc = payload_count_r + 16'd1;
  assign payload_last      = (payload_count_inc == hdr_length_r);
  // Length as it stands once the high byte lands
  assign length_zero       = (rx_byte == 8'd0) && (hdr_length_r[7:0] == 8'd0);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (sync_matched_r && (rx_byte == SYNC_SECOND)) phase_nxt = PH_HEADER;
      end
      PH_HEADER: begin
        if (header_count_r == HDR_POS_LEN_HI) begin
          phase_nxt = length_zero ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (payload_last) phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        if (check_count_r) phase_nxt = PH_HUNT;
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // Datapath updates and result for the current byte
  always_comb begin
    sync_matched_nxt  = sync_matched_r;
    header_count_nxt  = header_count_r;
    hdr_class_nxt     = hdr_class_r;
    hdr_id_nxt        = hdr_id_r;
    hdr_length_nxt    = hdr_length_r;
    payload_count_nxt = payload_count_r;
    sum_a_nxt         = sum_a_r;
    sum_b_nxt         = sum_b_r;
    first_check_nxt   = first_check_r;
    check_count_nxt   = check_count_r;

    res_nxt                = '0;

    unique case (phase_r)
      PH_HUNT: begin
        if (!sync_matched_r) begin
          sync_matched_nxt = (rx_byte == SYNC_FIRST);
        end else begin
          // Mismatch drops back to the hunt without rechecking this byte
          sync_matched_nxt = 1'b0;
          if (rx_byte == SYNC_SECOND) begin
            sum_a_nxt        = 8'd0;
            sum_b_nxt        = 8'd0;
            header_count_nxt = 2'd0;
          end
        end
      end
      PH_HEADER: begin
        sum_a_nxt = sum_a_add;
        sum_b_nxt = sum_b_add;
        unique case (header_count_r)
          HDR_POS_CLASS:  hdr_class_nxt = rx_byte;
          HDR_POS_ID:     hdr_id_nxt    = rx_byte;
          HDR_POS_LEN_LO: hdr_length_nxt = {hdr_length_r[15:8], rx_byte};
          HDR_POS_LEN_HI: hdr_length_nxt = {rx_byte, hdr_length_r[7:0]};
          default:        hdr_class_nxt = hdr_class_r;
        endcase
        if (header_count_r == HDR_POS_LEN_HI) begin
          header_count_nxt  = 2'd0;
          payload_count_nxt = 16'd0;
          check_count_nxt   = 1'b0;
        end else begin
          header_count_nxt  = header_count_r + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        sum_a_nxt              = sum_a_add;
        sum_b_nxt              = sum_b_add;
        res_nxt.payload_valid  = 1'b1;
        res_nxt.payload_byte   = rx_byte;
        res_nxt.payload_offset = payload_count_r;
        if (payload_last) begin
          payload_count_nxt = 16'd0;
          check_count_nxt   = 1'b0;
        end else begin
          payload_count_nxt = payload_count_inc;
        end
      end
      PH_CHECK: begin
        if (!check_count_r) begin
          first_check_nxt = rx_byte;
          check_count_nxt = 1'b1;
        end else begin
          check_count_nxt     = 1'b0;
          sync_matched_nxt    = 1'b0;
          res_nxt.frame_done  = 1'b1;
          res_nxt.checksum_ok = (first_check_r == sum_a_r) && (rx_byte == sum_b_r);
        end
      end
      default: sync_matched_nxt = 1'b0;
    endcase

    // Header fields as they stand after this byte
    res_nxt.msg_class  = hdr_class_nxt;
    res_nxt.msg_id     = hdr_id_nxt;
    res_nxt.msg_length = hdr_length_nxt;
  end

  // Advance state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HUNT;
      sync_matched_r  <= 1'b0;
      header_count_r  <= 2'd0;
      hdr_class_r     <= 8'd0;
      hdr_id_r        <= 8'd0;
      hdr_length_r    <= 16'd0;
      payload_count_r <= 16'd0;
      sum_a_r         <= 8'd0;
      sum_b_r         <= 8'd0;
      first_check_r   <= 8'd0;
      check_count_r   <= 1'b0;
    end else if (step_en) begin
      phase_r         <= phase_nxt;
      sync_matched_r  <= sync_matched_nxt;
      header_count_r  <= header_count_nxt;
      hdr_class_r     <= hdr_class_nxt;
      hdr_id_r        <= hdr_id_nxt;
      hdr_length_r    <= hdr_length_nxt;
      payload_count_r <= payload_count_nxt;
      sum_a_r         <= sum_a_nxt;
      sum_b_r         <= sum_b_nxt;
      first_check_r   <= first_check_nxt;
      check_count_r   <= check_count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sfpf_out_reg.sv
// Result register with valid/stall handshake toward the receiver.
// Depends on sfpf_pkg for the result struct.
`default_nettype none

module sfpf_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire sfpf_pkg::result_t res_nxt,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic                   busy,
  output sfpf_pkg::result_t      res
);
  import sfpf_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Slot is busy while a result waits under stall
  assign busy = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the new result on each input transfer
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

>>> rtl/sync_frame_parser_fletcher_top.sv
// Top level of the sync frame parser with Fletcher-8 check.
// Depends on sfpf_pkg, sfpf_core and sfpf_out_reg.
//
// Usage:
//   Input channel: one received byte per transfer on in_rx_byte
//   (in_valid / in_stall). Every input byte yields exactly one result.
//   Result channel: out_valid / out_stall with the payload byte, its
//   offset, the current class, id and length, and on the last checksum
//   byte frame_done and checksum_ok.
//   The result for a byte appears in the cycle after its transfer.
//   Throughput: one byte per cycle when not stalled; the parser state and the result
//   register update in the same edge, so a byte can follow in every cycle.
//   A result waiting in the output register is replaced in the same edge
//   it is taken, so back-to-back flow continues under no stall.
//   Stall: while out_valid is high and out_stall is high the result is
//   held and in_stall is raised, so no byte is taken.
//   Reset (rst_n low, synchronous): the parser returns to sync hunt, all
//   sums and header fields clear, and the result register empties.
`default_nettype none

module sync_frame_parser_fletcher_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_payload_valid,
  output logic [7:0]       out_payload_byte,
  output logic [15:0]      out_payload_offset,
  output logic [7:0]       out_msg_class,
  output logic [7:0]       out_msg_id,
  output logic [15:0]      out_msg_length,
  output logic             out_frame_done,
  output logic             out_checksum_ok
);
  import sfpf_pkg::*;

  logic    busy;
  logic    in_xfer;
  result_t res_nxt;
  result_t res;

  // Accept a byte whenever the result slot is free or being emptied
  assign in_stall = busy;
  assign in_xfer  = in_valid && !busy;

  sfpf_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_xfer),
    .rx_byte (in_rx_byte),
    .res_nxt (res_nxt)
  );

  sfpf_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer),
    .res_nxt   (res_nxt),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy      (busy),
    .res       (res)
  );

  // Unpack the result onto the ports
  assign out_payload_valid  = res.payload_valid;
  assign out_payload_byte   = res.payload_byte;
  assign out_payload_offset = res.payload_offset;
  assign out_msg_class      = res.msg_class;
  assign out_msg_id         = res.msg_id;
  assign out_msg_length     = res.msg_length;
  assign out_frame_done     = res.frame_done;
  assign out_checksum_ok    = res.checksum_ok;

endmodule

`default_nettype wire
